### rtl/core/pidz_pkg.sv
// pidz_pkg: shared widths, register codes and stage types of the pid regulator
package pidz_pkg;

    localparam int DATA_W     = 16;
    localparam int ZONE_W     = 17;
    localparam int ERR_W      = 17;
    localparam int DERIV_W    = 18;
    localparam int INTEG_W    = 32;
    localparam int ACC_W      = INTEG_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PROP_W     = DATA_W + ERR_W;
    localparam int INTP_W     = DATA_W + INTEG_W;
    localparam int DERP_W     = DATA_W + DERIV_W;
    localparam int SUM_W      = 49;
    localparam int FRAC_W     = 8;
    localparam int SHIFT_W    = SUM_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] INTEG_MAX = 33'sd2147483647;
    localparam logic signed [ACC_W-1:0] INTEG_MIN = -33'sd2147483647;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET      = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_DRIVE_UPPER = 3'd4,
        REG_DRIVE_LOWER = 3'd5,
        REG_INTEG_ZONE  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic signed [DATA_W-1:0] drive_upper;
        logic signed [DATA_W-1:0] drive_lower;
        logic        [ZONE_W-1:0] integ_zone;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } err_stage_t;

    typedef struct packed {
        logic signed [PROP_W-1:0] prop;
        logic signed [INTP_W-1:0] intp;
        logic signed [DERP_W-1:0] derp;
    } prod_stage_t;

endpackage

### rtl/core/pid_controller_integral_zone_unit.sv
// pid_controller_integral_zone_unit: top level of the pid regulator with integral zone and clamp
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_measured_value  16 signed
//  m_       out        m_valid / m_ready    m_drive_value     16 signed
//  cfg_     in         cfg_wr_en            cfg_index 3, cfg_wr_data 17
//
//  one item per cycle while m_ready is high; items pass the error, product and drive registers
//  the integral and last error update in the accept cycle, so the loop closes in one stage
//  reset clears the configuration registers, loop state and stage valids
//  each stage holds its item while the next one is full; bubbles close up under a stall
module pid_controller_integral_zone_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pidz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidz_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pidz_pkg::DATA_W-1:0]       s_measured_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pidz_pkg::DATA_W-1:0]       m_drive_value
);
    import pidz_pkg::*;

    cfg_t        cfg;
    err_stage_t  err_data;
    prod_stage_t prod_data;
    logic        err_valid;
    logic        err_ready;
    logic        prod_valid;
    logic        prod_ready;

    pidz_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pidz_error_stage u_error (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .measured_value (s_measured_value),
        .out_valid      (err_valid),
        .out_ready      (err_ready),
        .out_data       (err_data)
    );

    pidz_product_stage u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    pidz_drive_stage u_drive (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (prod_valid),
        .in_ready    (prod_ready),
        .in_data     (prod_data),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .drive_value (m_drive_value)
    );

endmodule

### rtl/core/pidz_cfg_regs.sv
// pidz_cfg_regs: configuration register file written through the plain write port
module pidz_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pidz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidz_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output pidz_pkg::cfg_t                    cfg
);
    import pidz_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET:      cfg_next.target_value = cfg_wr_data[DATA_W-1:0];
                REG_PROP_GAIN:   cfg_next.prop_gain    = cfg_wr_data[DATA_W-1:0];
                REG_INTEG_GAIN:  cfg_next.integ_gain   = cfg_wr_data[DATA_W-1:0];
                REG_DERIV_GAIN:  cfg_next.deriv_gain   = cfg_wr_data[DATA_W-1:0];
                REG_DRIVE_UPPER: cfg_next.drive_upper  = cfg_wr_data[DATA_W-1:0];
                REG_DRIVE_LOWER: cfg_next.drive_lower  = cfg_wr_data[DATA_W-1:0];
                REG_INTEG_ZONE:  cfg_next.integ_zone   = cfg_wr_data[ZONE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/pidz_error_stage.sv
// pidz_error_stage: error, integral with zone and saturation, derivative, and loop state
module pidz_error_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pidz_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pidz_pkg::DATA_W-1:0]    measured_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pidz_pkg::err_stage_t           out_data
);
    import pidz_pkg::*;

    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ERR_W-1:0]   last_error_next;
    logic signed [INTEG_W-1:0] integ_sum_reg;
    logic signed [INTEG_W-1:0] integ_sum_next;
    logic                      valid_reg;
    logic                      valid_next;
    err_stage_t                data_reg;
    err_stage_t                data_next;

    logic signed [ERR_W-1:0]   err;
    logic        [ERR_W-1:0]   mag;
    logic                      zone_hit;
    logic signed [ACC_W-1:0]   acc;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [DERIV_W-1:0] deriv;
    logic                      load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        err      = {cfg.target_value[DATA_W-1], cfg.target_value}
                 - {measured_value[DATA_W-1], measured_value};
        mag      = err[ERR_W-1] ? (~err + 1'b1) : err;
        zone_hit = mag < cfg.integ_zone;
        acc      = {integ_sum_reg[INTEG_W-1], integ_sum_reg}
                 + {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
        if (!zone_hit) begin
            integ_new = '0;
        end else if (acc > INTEG_MAX) begin
            integ_new = INTEG_MAX[INTEG_W-1:0];
        end else if (acc < INTEG_MIN) begin
            integ_new = INTEG_MIN[INTEG_W-1:0];
        end else begin
            integ_new = acc[INTEG_W-1:0];
        end
        deriv = {err[ERR_W-1], err} - {last_error_reg[ERR_W-1], last_error_reg};

        last_error_next = last_error_reg;
        integ_sum_next  = integ_sum_reg;
        data_next       = data_reg;
        valid_next      = valid_reg;
        if (load) begin
            last_error_next = err;
            integ_sum_next  = integ_new;
            data_next.err   = err;
            data_next.integ = integ_new;
            data_next.deriv = deriv;
            valid_next      = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integ_sum_reg  <= '0;
            valid_reg      <= 1'b0;
        end else begin
            last_error_reg <= last_error_next;
            integ_sum_reg  <= integ_sum_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/pidz_product_stage.sv
// pidz_product_stage: the three gain multiplications, registered
module pidz_product_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pidz_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pidz_pkg::err_stage_t    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pidz_pkg::prod_stage_t   out_data
);
    import pidz_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    prod_stage_t data_reg;
    prod_stage_t data_next;
    logic        load;

    logic signed [PROP_W-1:0] prop;
    logic signed [INTP_W-1:0] intp;
    logic signed [DERP_W-1:0] derp;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        prop = $signed(cfg.prop_gain)  * $signed(in_data.err);
        intp = $signed(cfg.integ_gain) * $signed(in_data.integ);
        derp = $signed(cfg.deriv_gain) * $signed(in_data.deriv);

        data_next  = data_reg;
        valid_next = valid_reg;
        if (load) begin
            data_next.prop = prop;
            data_next.intp = intp;
            data_next.derp = derp;
            valid_next     = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/pidz_drive_stage.sv
// pidz_drive_stage: product sum, floor shift, clamp and output register
module pidz_drive_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pidz_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pidz_pkg::prod_stage_t          in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pidz_pkg::DATA_W-1:0]    drive_value
);
    import pidz_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [DATA_W-1:0]        drive_reg;
    logic [DATA_W-1:0]        drive_next;
    logic                     load;

    logic signed [SUM_W-1:0]   sum;
    logic signed [SHIFT_W-1:0] scaled;
    logic signed [SHIFT_W-1:0] upper;
    logic signed [SHIFT_W-1:0] lower;
    logic        [DATA_W-1:0]  clamped;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        sum    = {{(SUM_W-PROP_W){in_data.prop[PROP_W-1]}}, in_data.prop}
               + {{(SUM_W-INTP_W){in_data.intp[INTP_W-1]}}, in_data.intp}
               + {{(SUM_W-DERP_W){in_data.derp[DERP_W-1]}}, in_data.derp};
        // dropping the fraction bits floors toward minus infinity
        scaled = sum[SUM_W-1:FRAC_W];
        upper  = {{(SHIFT_W-DATA_W){cfg.drive_upper[DATA_W-1]}}, cfg.drive_upper};
        lower  = {{(SHIFT_W-DATA_W){cfg.drive_lower[DATA_W-1]}}, cfg.drive_lower};
        if (scaled > upper) begin
            clamped = cfg.drive_upper;
        end else if (scaled < lower) begin
            clamped = cfg.drive_lower;
        end else begin
            clamped = scaled[DATA_W-1:0];
        end

        drive_next = drive_reg;
        valid_next = valid_reg;
        if (load) begin
            drive_next = clamped;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drive_reg <= drive_next;
    end

    assign out_valid   = valid_reg;
    assign drive_value = drive_reg;

endmodule
